// ----- hw/rtl/ptt_pkg.sv -----
`default_nettype none

package ptt_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int SLOT_W      = 8;
    localparam int PIPE_W      = 5;

    typedef enum logic [0:0] {
        FUNC_MARK   = 1'b0,
        FUNC_SIGNAL = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slot;
        logic [PIPE_W-1:0] pipe;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [PIPE_W-1:0] pipe;
    } result_t;

    typedef struct packed {
        logic             res_valid;
        result_t          res;
        logic [CNT_W-1:0] count;
    } seq_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pending_transfer_tracker_core.sv -----
`default_nettype none

// Pending transfer tracker: keeps a dense table of outstanding transfers keyed by
// completion descriptor address. A mark (func 0) appends an entry and answers
// inserted, or full when all TABLE_DEPTH entries are in use. A signal (func 1)
// searches from the lowest index, removes the first matching entry by moving the
// last entry into its place, and answers with its slot and pipe, or not found.
// A signal that hits stops the sweep at the matching entry; a miss reads every entry
// of the table before it answers, and a miss on an empty table reads no entry at all.
// The sweep is set by the single read port of the entry RAM, one entry a cycle.
// A result that cannot enter the output register holds the core until it frees.
// The next transfer can be taken in the cycle in which m_valid rises, while the previous
// result still sits in the output register.
module pending_transfer_tracker_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_func,
    input  wire logic [ptt_pkg::ADDR_W-1:0] s_desc_address,
    input  wire logic [ptt_pkg::SLOT_W-1:0] s_dev_slot,
    input  wire logic [ptt_pkg::PIPE_W-1:0] s_pipe_index,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [1:0]                      m_status,
    output logic [ptt_pkg::SLOT_W-1:0]      m_found_slot,
    output logic [ptt_pkg::PIPE_W-1:0]      m_found_pipe
);

    import ptt_pkg::*;

    mem_req_t   mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    seq_stat_t  stat;
    logic       out_free;
    logic       m_valid_reg, m_valid_next;
    result_t    m_res_reg;

    assign out_free = !m_valid_reg || m_ready;

    ptt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rdata)
    );

    ptt_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (func_t'(s_func)),
        .s_desc_address (s_desc_address),
        .s_dev_slot     (s_dev_slot),
        .s_pipe_index   (s_pipe_index),
        .mem_req        (mem_req),
        .mem_rdata      (entry_t'(mem_rdata)),
        .out_free       (out_free),
        .stat           (stat)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (stat.res_valid && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.res_valid && out_free) begin
            m_res_reg <= stat.res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_res_reg.status;
    assign m_found_slot = m_res_reg.slot;
    assign m_found_pipe = m_res_reg.pipe;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !stat.res_valid)
        else $error("input taken while a result is pending");

    a_mark_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_MARK) && (stat.count != CNT_W'(TABLE_DEPTH)))
        |=> (stat.count == $past(stat.count) + 1'b1))
        else $error("mark did not append an entry");

endmodule

`default_nettype wire

// ----- hw/rtl/ptt_ram.sv -----
`default_nettype none

module ptt_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 77,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ptt_seq.sv -----
`default_nettype none

module ptt_seq (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire ptt_pkg::func_t            s_func,
    input  wire logic [ptt_pkg::ADDR_W-1:0] s_desc_address,
    input  wire logic [ptt_pkg::SLOT_W-1:0] s_dev_slot,
    input  wire logic [ptt_pkg::PIPE_W-1:0] s_pipe_index,
    output ptt_pkg::mem_req_t              mem_req,
    input  wire ptt_pkg::entry_t           mem_rdata,
    input  wire logic                      out_free,
    output ptt_pkg::seq_stat_t             stat
);

    import ptt_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [ADDR_W-1:0] key_reg, key_next;
    result_t           res_reg, res_next;
    logic [CNT_W-1:0]  last_cnt;
    logic              match;

    assign last_cnt = count_reg - 1'b1;
    assign match    = chk_valid_reg && (mem_rdata.addr == key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_idx_next   = hit_idx_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        mem_req        = '0;
        s_ready        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_MARK) begin
                        if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            res_next = '{status: ST_FULL, slot: '0, pipe: '0};
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = count_reg[IDX_W-1:0];
                            mem_req.wr_data = '{addr: s_desc_address, slot: s_dev_slot,
                                                pipe: s_pipe_index};
                            count_next      = count_reg + 1'b1;
                            res_next = '{status: ST_INSERTED, slot: '0, pipe: '0};
                        end
                        state_next = S_DONE;
                    end else begin
                        key_next = s_desc_address;
                        idx_next = '0;
                        if (count_reg == '0) begin
                            res_next   = '{status: ST_MISSING, slot: '0, pipe: '0};
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    // fetch the tail entry to fill the hole
                    res_next = '{status: ST_REMOVED, slot: mem_rdata.slot,
                                 pipe: mem_rdata.pipe};
                    hit_idx_next    = chk_idx_reg;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = last_cnt[IDX_W-1:0];
                    state_next      = S_MOVE;
                end else if (idx_reg < count_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg[IDX_W-1:0];
                    idx_next        = idx_reg + 1'b1;
                    chk_valid_next  = 1'b1;
                    chk_idx_next    = idx_reg[IDX_W-1:0];
                end else if (!chk_valid_reg) begin
                    res_next   = '{status: ST_MISSING, slot: '0, pipe: '0};
                    state_next = S_DONE;
                end
            end
            S_MOVE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = hit_idx_reg;
                mem_req.wr_data = mem_rdata;
                count_next      = last_cnt;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat.res_valid = (state_reg == S_DONE);
    assign stat.res       = res_reg;
    assign stat.count     = count_reg;

endmodule

`default_nettype wire
